// File: rtl/rc6_pkg.sv
`timescale 1ns / 1ps
package rc6_pkg;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  localparam logic [1:0] KIND_ENC    = 2'd0;
  localparam logic [1:0] KIND_DEC    = 2'd1;
  localparam logic [1:0] KIND_EXPAND = 2'd2;

  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_KSIZE = 3'd4;
  localparam logic [2:0] CFG_ROUND = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } rc6_in_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [31:0] out_d;
    logic        status;
  } rc6_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_WH_RD0,
    ST_WH_RD1,
    ST_RND_RD0,
    ST_RND_RD1,
    ST_RND_EXE,
    ST_FIN_RD1,
    ST_FIN,
    ST_OUT
  } rc6_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage

// File: rtl/rc6_block_cipher.sv
`timescale 1ns / 1ps
// RC6-32 cipher with a single-port round key memory (registered read).
// Encrypt/decrypt: two key reads per round through the one memory port, with
// the round math in the second state of each round.
// Key expansion: init fills the key memory, then each mixing step reads and writes it.
// One transaction at a time; the next is taken the cycle after the result is
// taken. Reset (rst_n low, synchronous) clears control and config only.
module rc6_block_cipher #(
  parameter int MAX_ROUNDS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rc6_pkg::rc6_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rc6_pkg::rc6_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata
);
  import rc6_pkg::*;

  localparam int DEPTH = 2 * MAX_ROUNDS + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROUNDS + 1);
  localparam int SW    = $clog2(3 * DEPTH + 1);

  // configuration registers
  logic [63:0] key_r [4];
  logic [1:0]  ksize_r;
  logic [4:0]  rounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0; key_r[1] <= '0; key_r[2] <= '0; key_r[3] <= '0;
      ksize_r  <= '0;
      rounds_r <= 5'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0:  key_r[0] <= cfg_wdata;
        CFG_KEY1:  key_r[1] <= cfg_wdata;
        CFG_KEY2:  key_r[2] <= cfg_wdata;
        CFG_KEY3:  key_r[3] <= cfg_wdata;
        CFG_KSIZE: ksize_r  <= cfg_wdata[1:0];
        CFG_ROUND: rounds_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // effective round count: zero acts as one, saturate at MAX_ROUNDS
  logic [RW-1:0] eff_rounds;
  always_comb begin
    if (rounds_r == 5'd0) eff_rounds = RW'(1);
    else if (32'(rounds_r) > MAX_ROUNDS) eff_rounds = RW'(MAX_ROUNDS);
    else eff_rounds = RW'(rounds_r);
  end

  // round key memory
  logic [31:0] rk_mem [DEPTH];
  logic [31:0] rk_q;
  logic        rk_we;
  logic [AW-1:0] rk_addr;
  logic [31:0] rk_wdata;

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_addr] <= rk_wdata;
    rk_q <= rk_mem[rk_addr];
  end

  // key word scratch: eight registers, indexed by the mixing position
  logic [31:0] kw_r [8];

  rc6_state_t     state_r, state_nxt;
  logic           ready_r, ready_nxt;
  logic [RW-1:0]  lrounds_r, lrounds_nxt;
  logic           dec_r, dec_nxt;
  logic [31:0]    a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0]    k0_r, k0_nxt;
  logic [AW-1:0]  i_r, i_nxt;
  logic [2:0]     j_r, j_nxt;
  logic [SW-1:0]  step_r, step_nxt;
  logic [RW-1:0]  rnd_r, rnd_nxt;
  logic [31:0]    prev_r, prev_nxt;
  rc6_out_t       out_r, out_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic           kw_we;
  logic [31:0]    kw_wdata;

  logic [AW-1:0]  tcnt;
  logic [3:0]     ccnt;
  logic [SW-1:0]  nsteps;
  logic [2:0]     code;

  assign tcnt  = AW'(2 * 32'(lrounds_r) + 4);
  assign code  = (ksize_r == 2'd3) ? 3'd2 : {1'b0, ksize_r};
  assign ccnt  = 4'd4 + {code, 1'b0};
  assign nsteps = (32'(ccnt) > 32'(tcnt)) ? SW'(3 * 32'(ccnt)) : SW'(3 * 32'(tcnt));

  // round datapath: key0 in k0_r, key1 in rk_q
  logic [31:0] mt, mu, t_f, u_f, ea, ec, dc, da, mx_a, mx_b;
  logic [31:0] pt, pu;
  assign pt  = b_r * (b_r * 32'd2 + 32'd1);
  assign pu  = d_r * (d_r * 32'd2 + 32'd1);
  assign mt  = rotl32(pt, 5'd5);
  assign mu  = rotl32(pu, 5'd5);
  assign ea  = rotl32(a_r ^ mt, mu[4:0]) + k0_r;
  assign ec  = rotl32(c_r ^ mu, mt[4:0]) + rk_q;
  // decrypt works on the pre-rotated words held in a..d
  assign t_f = mt;
  assign u_f = mu;
  assign dc  = rotr32(c_r - rk_q, t_f[4:0]) ^ u_f;
  assign da  = rotr32(a_r - k0_r, u_f[4:0]) ^ t_f;
  assign mx_a = rotl32(rk_q + a_r + b_r, 5'd3);
  assign mx_b = rotl32(kw_r[j_r] + mx_a + b_r, 5'(mx_a + b_r));

  always_ff @(posedge clk) begin
    if (kw_we) kw_r[j_r] <= kw_wdata;
    else if (state_r == ST_IDLE && in_valid && !in_stall &&
             in_data.kind == KIND_EXPAND) begin
      for (int s = 0; s < 4; s++) begin
        kw_r[2*s]   <= key_r[s][31:0];
        kw_r[2*s+1] <= key_r[s][63:32];
      end
    end
  end

  always_comb begin
    state_nxt = state_r; ready_nxt = ready_r; lrounds_nxt = lrounds_r;
    dec_nxt = dec_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    k0_nxt = k0_r; i_nxt = i_r; j_nxt = j_r; step_nxt = step_r; rnd_nxt = rnd_r;
    prev_nxt = prev_r; out_nxt = out_r; ovalid_nxt = ovalid_r;
    rk_we = 1'b0; rk_addr = i_r; rk_wdata = '0; kw_we = 1'b0; kw_wdata = mx_b;
    in_stall = 1'b1;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // take a new transaction only once the result slot is free
        in_stall = ovalid_r;
        if (in_valid && !ovalid_r) begin
          out_nxt = '0;
          a_nxt = in_data.word_a; b_nxt = in_data.word_b;
          c_nxt = in_data.word_c; d_nxt = in_data.word_d;
          dec_nxt = (in_data.kind == KIND_DEC);
          case (in_data.kind)
            KIND_EXPAND: begin
              lrounds_nxt = eff_rounds;
              i_nxt = '0; prev_nxt = MAGIC_P;
              state_nxt = ST_INIT;
            end
            KIND_ENC, KIND_DEC: begin
              if (!ready_r) begin
                out_nxt.status = 1'b1;
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_WH_RD0;
              end
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_INIT: begin
        // fill S[i] = P + i*Q
        rk_we = 1'b1; rk_wdata = prev_r; prev_nxt = prev_r + MAGIC_Q;
        if (i_r == tcnt - AW'(1)) begin
          i_nxt = '0; j_nxt = '0; step_nxt = '0;
          a_nxt = '0; b_nxt = '0;
          state_nxt = ST_MIX_RD;
        end else i_nxt = i_r + AW'(1);
      end
      ST_MIX_RD: state_nxt = ST_MIX_WR;
      ST_MIX_WR: begin
        rk_we = 1'b1; rk_wdata = mx_a; kw_we = 1'b1;
        a_nxt = mx_a; b_nxt = mx_b;
        i_nxt = (i_r == tcnt - AW'(1)) ? '0 : i_r + AW'(1);
        j_nxt = (4'(j_r) == ccnt - 4'd1) ? '0 : j_r + 3'd1;
        step_nxt = step_r + SW'(1);
        if (step_r == nsteps - SW'(1)) begin
          ready_nxt = 1'b1;
          a_nxt = '0; b_nxt = '0; c_nxt = '0; d_nxt = '0;
          state_nxt = ST_OUT;
        end else state_nxt = ST_MIX_RD;
      end
      ST_WH_RD0: begin
        // pre-whitening keys: S[0],S[1] or S[2r+2],S[2r+3]
        rk_addr = dec_r ? tcnt - AW'(2) : AW'(0);
        state_nxt = ST_WH_RD1;
      end
      ST_WH_RD1: begin
        rk_addr = dec_r ? tcnt - AW'(1) : AW'(1);
        k0_nxt = rk_q;
        rnd_nxt = dec_r ? lrounds_r : RW'(1);
        state_nxt = ST_RND_RD0;
      end
      ST_RND_RD0: begin
        rk_addr = AW'(2 * 32'(rnd_r));
        if (dec_r) begin
          a_nxt = a_r - k0_r; c_nxt = c_r - rk_q;
        end else begin
          b_nxt = b_r + k0_r; d_nxt = d_r + rk_q;
        end
        state_nxt = ST_RND_RD1;
      end
      ST_RND_RD1: begin
        rk_addr = AW'(2 * 32'(rnd_r) + 1);
        k0_nxt = rk_q;
        if (dec_r) begin
          // undo the word rotation before the round math
          a_nxt = d_r; b_nxt = a_r; c_nxt = b_r; d_nxt = c_r;
        end
        state_nxt = ST_RND_EXE;
      end
      ST_RND_EXE: begin
        if (dec_r) begin
          a_nxt = da; c_nxt = dc;
        end else begin
          a_nxt = b_r; b_nxt = c_r; c_nxt = d_r; d_nxt = ea;
          prev_nxt = ec;
        end
        if ((!dec_r && rnd_r == lrounds_r) || (dec_r && rnd_r == RW'(1))) begin
          rk_addr = dec_r ? AW'(0) : tcnt - AW'(2);
          state_nxt = ST_FIN_RD1;
        end else begin
          rnd_nxt = dec_r ? rnd_r - RW'(1) : rnd_r + RW'(1);
          state_nxt = ST_RND_RD1;
          rk_addr = AW'(2 * 32'(rnd_nxt));
        end
        if (!dec_r) c_nxt = d_r;
        if (!dec_r) b_nxt = ec;
      end
      ST_FIN_RD1: begin
        rk_addr = dec_r ? AW'(1) : tcnt - AW'(1);
        k0_nxt = rk_q;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (dec_r) begin
          out_nxt.out_a = a_r; out_nxt.out_b = b_r - k0_r;
          out_nxt.out_c = c_r; out_nxt.out_d = d_r - rk_q;
        end else begin
          out_nxt.out_a = a_r + k0_r; out_nxt.out_b = b_r;
          out_nxt.out_c = c_r + rk_q; out_nxt.out_d = d_r;
        end
        out_nxt.status = 1'b0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Encrypt round order: after EXE the new words are
  // (a,b,c,d) <- (b, ec, d, ea); the mux above writes b_nxt=ec, c_nxt=d.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ready_r <= 1'b0; ovalid_r <= 1'b0;
      lrounds_r <= RW'(1); dec_r <= 1'b0; i_r <= '0; j_r <= '0;
      step_r <= '0; rnd_r <= '0;
    end else begin
      state_r <= state_nxt; ready_r <= ready_nxt; ovalid_r <= ovalid_nxt;
      lrounds_r <= lrounds_nxt; dec_r <= dec_nxt; i_r <= i_nxt; j_r <= j_nxt;
      step_r <= step_nxt; rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
    k0_r <= k0_nxt; prev_r <= prev_nxt; out_r <= out_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rc6_pkg::*;

  localparam int MAX_R      = 20;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYC  = 400;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rc6_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  rc6_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  rc6_block_cipher #(.MAX_ROUNDS(MAX_R)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // 12 ns period
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Shadow copy of the cipher state, updated as registers are written and transactions are accepted.
  logic [63:0] key_reg [4];
  logic [1:0]  ksize_reg;
  logic [4:0]  rounds_reg;
  logic [31:0] rk [2*MAX_R+4];
  logic [31:0] kw [8];
  logic        keys_ready;
  int          keyed_rounds;

  rc6_in_t  pending_q [$];
  rc6_out_t result_q [$];

  int errors, idle_cycles, n_sent, n_enc, n_dec, n_exp, n_checked;
  bit noisy;
  bit in_taken;

  function automatic logic [31:0] rol(logic [31:0] x, logic [4:0] n);
    return (x << n) | (x >> (6'd32 - n));
  endfunction

  function automatic logic [31:0] ror(logic [31:0] x, logic [4:0] n);
    return (x >> n) | (x << (6'd32 - n));
  endfunction

  function automatic logic [31:0] quad_rot(logic [31:0] x);
    logic [31:0] p;
    p = x * (2 * x + 1);
    return rol(p, 5);
  endfunction

  // Run the key schedule from the current shadow registers.
  task automatic build_round_keys();
    int r, t, c, steps, i, j;
    logic [31:0] a, b;
    r = (rounds_reg == 0) ? 1 : (rounds_reg > MAX_R ? MAX_R : rounds_reg);
    t = 2 * r + 4;
    c = 4 + 2 * ((ksize_reg > 2) ? 2 : ksize_reg);
    for (int s = 0; s < 4; s++) begin
      kw[2*s]   = key_reg[s][31:0];
      kw[2*s+1] = key_reg[s][63:32];
    end
    rk[0] = MAGIC_P;
    for (int s = 1; s < t; s++) rk[s] = rk[s-1] + MAGIC_Q;
    steps = 3 * ((c > t) ? c : t);
    i = 0; j = 0; a = 0; b = 0;
    for (int s = 0; s < steps; s++) begin
      rk[i] = rol(rk[i] + a + b, 3);
      a = rk[i];
      kw[j] = rol(kw[j] + a + b, a[4:0] + b[4:0]);
      b = kw[j];
      i = (i + 1) % t;
      j = (j + 1) % c;
    end
    keyed_rounds = r;
    keys_ready   = 1'b1;
  endtask

  // Compute the expected result of one accepted transaction.
  task automatic predict_block(input rc6_in_t it, output rc6_out_t res);
    logic [31:0] a, b, c, d, t, u, tmp;
    int r;
    res = '0;
    if (it.kind == KIND_EXPAND) begin
      build_round_keys();
      return;
    end
    if (it.kind != KIND_ENC && it.kind != KIND_DEC) return;
    if (!keys_ready) begin
      res.status = 1'b1;
      return;
    end
    r = keyed_rounds;
    a = it.word_a; b = it.word_b; c = it.word_c; d = it.word_d;
    if (it.kind == KIND_ENC) begin
      b += rk[0];
      d += rk[1];
      for (int i = 1; i <= r; i++) begin
        t = quad_rot(b);
        u = quad_rot(d);
        a = rol(a ^ t, u[4:0]) + rk[2*i];
        c = rol(c ^ u, t[4:0]) + rk[2*i+1];
        tmp = a; a = b; b = c; c = d; d = tmp;
      end
      a += rk[2*r+2];
      c += rk[2*r+3];
    end else begin
      c -= rk[2*r+3];
      a -= rk[2*r+2];
      for (int i = r; i > 0; i--) begin
        tmp = d; d = c; c = b; b = a; a = tmp;
        t = quad_rot(b);
        u = quad_rot(d);
        c = ror(c - rk[2*i+1], t[4:0]) ^ u;
        a = ror(a - rk[2*i], u[4:0]) ^ t;
      end
      d -= rk[1];
      b -= rk[0];
    end
    res.out_a = a; res.out_b = b; res.out_c = c; res.out_d = d;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Driver: drop the head once the monitor saw it accepted, then present the
  // next one; hold the payload while a transaction waits.
  always @(negedge clk) begin
    bit holding;
    if (rst_n) begin
      holding = in_valid && !in_taken;
      if (in_taken) begin
        void'(pending_q.pop_front());
        n_sent++;
        in_taken = 1'b0;
      end
      if (!holding) begin
        if (pending_q.size() > 0 && (!noisy || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          in_data  <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= noisy && ($urandom_range(99) < 25);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    rc6_out_t want;
    rc6_out_t got;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        predict_block(in_data, want);
        result_q.push_back(want);
        case (in_data.kind)
          KIND_ENC:    n_enc++;
          KIND_DEC:    n_dec++;
          KIND_EXPAND: n_exp++;
          default: ;
        endcase
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        got = out_data;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", got.out_a, '0);
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (got.out_a !== want.out_a) report_mismatch("out_a", got.out_a, want.out_a);
          if (got.out_b !== want.out_b) report_mismatch("out_b", got.out_b, want.out_b);
          if (got.out_c !== want.out_c) report_mismatch("out_c", got.out_c, want.out_c);
          if (got.out_d !== want.out_d) report_mismatch("out_d", got.out_d, want.out_d);
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", result_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Write one register at a falling edge; block is idle here.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx <= CFG_KEY3) key_reg[idx] = val;
    else if (idx == CFG_KSIZE) ksize_reg = val[1:0];
    else if (idx == CFG_ROUND) rounds_reg = val[4:0];
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic rc6_in_t data_item(input logic [1:0] k);
    rc6_in_t it;
    it.kind   = k;
    it.word_a = $urandom; it.word_b = $urandom;
    it.word_c = $urandom; it.word_d = $urandom;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Load a key setting, expand, then queue a random mix of encrypt, decrypt, expand and ignored items.
  task automatic key_phase(input logic [1:0] ks, input logic [4:0] r, input int n_items);
    rc6_in_t it;
    for (int k = 0; k < 4; k++) write_reg(3'(CFG_KEY0 + k), rand64());
    write_reg(CFG_KSIZE, 64'(ks));
    write_reg(CFG_ROUND, 64'(r));
    pending_q.push_back('{kind: KIND_EXPAND, default: '0});
    for (int n = 0; n < n_items; n++) begin
      case ($urandom_range(9))
        0: it = data_item(KIND_IGNORED);
        1: it = '{kind: KIND_EXPAND, default: '0};
        default: it = data_item($urandom_range(1) ? KIND_ENC : KIND_DEC);
      endcase
      pending_q.push_back(it);
    end
    wait_drained();
  endtask

  initial begin
    rc6_in_t it;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    errors = 0; idle_cycles = 0; n_sent = 0; n_checked = 0;
    n_enc = 0; n_dec = 0; n_exp = 0; noisy = 1'b0; in_taken = 1'b0;
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    ksize_reg = 2'd0; rounds_reg = 5'd20; keys_ready = 1'b0; keyed_rounds = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: data before any expansion, ignored kind, then reset key.
    pending_q.push_back(data_item(KIND_ENC));
    pending_q.push_back(data_item(KIND_DEC));
    pending_q.push_back(data_item(KIND_IGNORED));
    pending_q.push_back('{kind: KIND_EXPAND, default: '0});
    pending_q.push_back('{kind: KIND_ENC, default: '0});
    pending_q.push_back('{kind: KIND_DEC, default: '0});
    it = '{kind: KIND_ENC, word_a: '1, word_b: '1, word_c: '1, word_d: '1};
    pending_q.push_back(it);
    it.kind = KIND_DEC;
    pending_q.push_back(it);
    wait_drained();

    // Extremes: all-ones key, 32-byte code three, zero and oversized rounds.
    for (int k = 0; k < 4; k++) write_reg(3'(CFG_KEY0 + k), '1);
    write_reg(CFG_KSIZE, 64'd3);
    write_reg(CFG_ROUND, 64'd0);
    pending_q.push_back('{kind: KIND_EXPAND, default: '0});
    pending_q.push_back(data_item(KIND_ENC));
    pending_q.push_back(data_item(KIND_DEC));
    wait_drained();
    write_reg(CFG_ROUND, 64'd31);
    // Latched round count still applies until re-expansion.
    pending_q.push_back(data_item(KIND_ENC));
    pending_q.push_back('{kind: KIND_EXPAND, default: '0});
    pending_q.push_back(data_item(KIND_ENC));
    pending_q.push_back(data_item(KIND_DEC));
    wait_drained();

    // Quiet stretch with no idling, then random phases with idling.
    key_phase(2'd0, 5'd20, 60);
    noisy = 1'b1;
    key_phase(2'd1, 5'd1, 150);
    key_phase(2'd2, 5'd20, 150);
    key_phase(2'd0, 5'(1 + $urandom_range(19)), 150);
    key_phase(2'd1, 5'(1 + $urandom_range(19)), 150);
    key_phase(2'(2 + $urandom_range(1)), 5'($urandom_range(31)), 150);

    $display("Covered %0d transactions: %0d encrypt, %0d decrypt, %0d key expansions;",
             n_sent, n_enc, n_dec, n_exp);
    $display("%0d results checked across several key sizes and round counts", n_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rc6_pkg.sv
rtl/rc6_block_cipher.sv
test/testbench.sv
